// ----- rtl/ota_ladder_lowpass_filter_assert.svh -----
// Assertion macros shared by the filter RTL.
`ifndef OTA_LADDER_LOWPASS_FILTER_ASSERT_SVH
`define OTA_LADDER_LOWPASS_FILTER_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define OLPF_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("olpf assertion failed");

// Check a condition in the cycle after its trigger.
`define OLPF_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("olpf assertion failed");

`endif

// ----- rtl/olpf_pkg.sv -----
`timescale 1ns / 1ps

package olpf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int NUM_STAGES_DEF = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 23;

  // shared multiplier operand and product widths
  localparam int MA_W = 28;
  localparam int MB_W = 24;
  localparam int P_W  = MA_W + MB_W;

  localparam logic [15:0] K_POINT4  = 16'd26214;
  localparam logic [15:0] K_INV_VT  = 16'd36409;
  localparam logic [16:0] K_VT      = 17'd117965;
  localparam logic [15:0] TANH_MAX  = 16'd65492;
  localparam logic [31:0] K_LIMIT   = 32'd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF    = 3'd0,
    REG_RESONANCE = 3'd1,
    REG_ATTEN     = 3'd2,
    REG_OUT_GAIN  = 3'd3,
    REG_SLEW      = 3'd4,
    REG_CLIP      = 3'd5
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ATT, S_K04, S_COMP, S_AC, S_PRV, S_FBT,
    S_TH0, S_TH1,
    S_FB1, S_FB2, S_FB3, S_FB4, S_FB5, S_FB6,
    S_ST0, S_ST1, S_ST2, S_ST3, S_ST4, S_ST5, S_ST6, S_ST7, S_ST8,
    S_OUT0, S_OUT1, S_DONE
  } olpf_state_t;

  // one tanh segment: sign, saturation, base value and slope inputs
  typedef struct packed {
    logic        neg;
    logic        sat;
    logic [15:0] lo;
    logic [12:0] d;
    logic [12:0] frac;
  } tanh_seg_t;

  // tanh over 0..4 in steps of 1/8, Q0.16
  function automatic logic [15:0] tanh_tab(input logic [5:0] i);
    logic [15:0] r;
    case (i)
      6'd0:  r = 16'd0;     6'd1:  r = 16'd8150;  6'd2:  r = 16'd16051;
      6'd3:  r = 16'd23485; 6'd4:  r = 16'd30285; 6'd5:  r = 16'd36346;
      6'd6:  r = 16'd41625; 6'd7:  r = 16'd46142; 6'd8:  r = 16'd49912;
      6'd9:  r = 16'd53038; 6'd10: r = 16'd55593; 6'd11: r = 16'd57660;
      6'd12: r = 16'd59320; 6'd13: r = 16'd60643; 6'd14: r = 16'd61694;
      6'd15: r = 16'd62524; 6'd16: r = 16'd63179; 6'd17: r = 16'd63693;
      6'd18: r = 16'd64096; 6'd19: r = 16'd64412; 6'd20: r = 16'd64659;
      6'd21: r = 16'd64852; 6'd22: r = 16'd65003; 6'd23: r = 16'd65120;
      6'd24: r = 16'd65212; 6'd25: r = 16'd65283; 6'd26: r = 16'd65339;
      6'd27: r = 16'd65383; 6'd28: r = 16'd65417; 6'd29: r = 16'd65443;
      6'd30: r = 16'd65464; 6'd31: r = 16'd65480;
      default: r = TANH_MAX;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/olpf_tanh_seg.sv -----
`timescale 1ns / 1ps

module olpf_tanh_seg
  import olpf_pkg::*;
(
  input  logic signed [SAMPLE_BITS-1:0] t,
  output tanh_seg_t                     seg
);

  logic [SAMPLE_BITS-1:0] a;
  logic [4:0]             idx;
  logic [15:0]            hi;

  // magnitude; the most negative value maps to 2^23 as unsigned
  assign a   = t[SAMPLE_BITS-1] ? (~t + 1'b1) : t;
  assign idx = a[17:13];
  assign hi  = tanh_tab({1'b0, idx} + 6'd1);

  always_comb begin
    seg.neg  = t[SAMPLE_BITS-1];
    seg.sat  = |a[SAMPLE_BITS-1:18];
    seg.lo   = tanh_tab({1'b0, idx});
    seg.d    = 13'(hi - seg.lo);
    seg.frac = a[12:0];
  end

endmodule

// ----- rtl/ota_ladder_lowpass_filter.sv -----
// Four-pole nonlinear ladder lowpass on signed Q8.16 samples. Each accepted
// sample yields exactly one output sample. The input is attenuated, gain
// compensated by 1+0.4k and reduced by k times a smoothed, soft-clipped copy
// of the last output, then runs through NUM_STAGES trapezoidal one-pole stages
// that each saturate input and state through a table-interpolated tanh and
// clip their output at the stage clip limit. Any state of magnitude 100.0 or
// more is zeroed after the sample. Every product, including the tanh
// interpolation, goes one at a time through the single registered
// multiplier. in_ready is high only while the sequencer is idle, so a new
// request is taken only after the previous sample has finished. A finished
// sample waits in the output register and the next request is taken while it
// waits; if the output register is still full when the next sample finishes,
// the sequencer holds in its last state and the input stalls. Configuration
// registers (index 0 cutoff coefficient, 1 resonance amount, 2 input gain, 3
// output gain, 4 feedback slew, 5 stage clip limit) are always writable;
// write them only while the filter is idle. Writes to other indexes are
// dropped.
`timescale 1ns / 1ps
`include "ota_ladder_lowpass_filter_assert.svh"

module ota_ladder_lowpass_filter
  import olpf_pkg::*;
#(
  parameter int NUM_STAGES = NUM_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int IW = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;

  // saturate to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [31:0] v);
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd8388607;
    lo = -32'sd8388608;
    if (v > hi) return hi[SAMPLE_BITS-1:0];
    else if (v < lo) return lo[SAMPLE_BITS-1:0];
    else return v[SAMPLE_BITS-1:0];
  endfunction

  // zero a runaway value
  function automatic logic signed [31:0] kill(input logic signed [31:0] v);
    if (v >= signed'(K_LIMIT) || v <= -signed'(K_LIMIT)) return 32'sd0;
    else return v;
  endfunction

  // apply the sign of the tanh argument
  function automatic logic signed [16:0] seg_sign(input logic n, input logic [15:0] m);
    logic signed [16:0] s;
    s = signed'({1'b0, m});
    return n ? -s : s;
  endfunction

  // configuration
  logic [15:0] cutoff_r;
  logic [16:0] reson_r;
  logic [16:0] atten_r;
  logic [22:0] out_gain_r;
  logic [16:0] slew_r;
  logic [22:0] clip_r;

  // sequencer
  olpf_state_t st_r, st_nxt, ret_r;
  logic [IW-1:0] idx_r;
  logic          load_out;

  // shared multiplier
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [P_W-1:0]  p_nxt, p_r, p16;

  // datapath
  logic signed [SAMPLE_BITS-1:0] x_r, t_r, y_r, res_r, prev_r, diff_r;
  logic signed [SAMPLE_BITS-1:0] s_r [NUM_STAGES];
  logic signed [24:0]            att_r;
  logic [18:0]                   comp_r;
  logic signed [27:0]            ac_r;
  logic signed [26:0]            fs_r;
  logic signed [16:0]            r_r;
  logic signed [17:0]            ca_r;
  logic                          neg_r, sat_r;
  logic [15:0]                   lo_r;
  logic out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;

  tanh_seg_t seg;
  logic [18:0] k;
  logic [15:0] rr;
  logic signed [18:0] sfb, v, cs, dd;
  logic signed [24:0] yy, clip25, ycl;
  logic signed [25:0] nv;
  logic signed [31:0] u32;

  olpf_tanh_seg u_tanh_seg (
    .t   (t_r),
    .seg (seg)
  );

  assign k        = {reson_r, 2'b00};
  assign p_nxt    = ma * mb;
  assign p16      = p_r >>> 16;
  assign in_ready = (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_sample_out = out_sample_r;

  // helpers for the interpolation, feedback and stage updates
  assign rr     = sat_r ? TANH_MAX : (lo_r + 16'(p_r[25:13]));
  assign sfb    = p_r[19:1];
  assign cs     = p16[18:0];
  assign dd     = 19'(ca_r) - cs;
  assign v      = p16[18:0];
  assign yy     = 25'(s_r[idx_r]) + 25'(v);
  assign nv     = 26'(yy) + 26'(v);
  assign clip25 = signed'({2'b00, clip_r});
  assign ycl    = (yy > clip25) ? clip25 : ((yy < -clip25) ? -clip25 : yy);
  assign u32    = 32'(ac_r) - p16[31:0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r   <= 16'd32768;
      reson_r    <= 17'd0;
      atten_r    <= 17'd16384;
      out_gain_r <= 23'd262144;
      slew_r     <= 17'd32768;
      clip_r     <= 23'd262144;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CUTOFF:    cutoff_r   <= cfg_data[15:0];
        REG_RESONANCE: reson_r    <= cfg_data[16:0];
        REG_ATTEN:     atten_r    <= cfg_data[16:0];
        REG_OUT_GAIN:  out_gain_r <= cfg_data;
        REG_SLEW:      slew_r     <= cfg_data[16:0];
        REG_CLIP:      clip_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // next state and multiplier operand select
  always_comb begin
    st_nxt   = st_r;
    ma       = '0;
    mb       = '0;
    load_out = 1'b0;
    case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_ATT;
      S_ATT: begin
        ma = MA_W'(x_r);
        mb = signed'(MB_W'(atten_r));
        st_nxt = S_K04;
      end
      S_K04: begin
        ma = signed'(MA_W'(k));
        mb = signed'(MB_W'(K_POINT4));
        st_nxt = S_COMP;
      end
      S_COMP: st_nxt = S_AC;
      S_AC: begin
        ma = MA_W'(att_r);
        mb = signed'(MB_W'(comp_r));
        st_nxt = S_PRV;
      end
      S_PRV: begin
        ma = MA_W'(prev_r);
        mb = signed'(MB_W'(K_POINT4));
        st_nxt = S_FBT;
      end
      S_FBT: st_nxt = S_TH0;
      S_TH0: begin
        ma = signed'(MA_W'(seg.d));
        mb = signed'(MB_W'(seg.frac));
        st_nxt = S_TH1;
      end
      S_TH1: st_nxt = ret_r;
      S_FB1: begin
        ma = MA_W'(r_r);
        mb = MB_W'(5);
        st_nxt = S_FB2;
      end
      S_FB2: st_nxt = S_FB3;
      S_FB3: begin
        ma = MA_W'(diff_r);
        mb = signed'(MB_W'(slew_r));
        st_nxt = S_FB4;
      end
      S_FB4: st_nxt = S_FB5;
      S_FB5: begin
        ma = MA_W'(fs_r);
        mb = signed'(MB_W'(k));
        st_nxt = S_FB6;
      end
      S_FB6: st_nxt = S_ST0;
      S_ST0: begin
        ma = MA_W'(y_r);
        mb = signed'(MB_W'(K_INV_VT));
        st_nxt = S_ST1;
      end
      S_ST1: st_nxt = S_TH0;
      S_ST2: begin
        ma = MA_W'(r_r);
        mb = signed'(MB_W'(K_VT));
        st_nxt = S_ST3;
      end
      S_ST3: begin
        ma = MA_W'(s_r[idx_r]);
        mb = signed'(MB_W'(K_INV_VT));
        st_nxt = S_ST4;
      end
      S_ST4: st_nxt = S_TH0;
      S_ST5: begin
        ma = MA_W'(r_r);
        mb = signed'(MB_W'(K_VT));
        st_nxt = S_ST6;
      end
      S_ST6: st_nxt = S_ST7;
      S_ST7: begin
        ma = MA_W'(diff_r);
        mb = signed'(MB_W'(cutoff_r));
        st_nxt = S_ST8;
      end
      S_ST8: st_nxt = (idx_r == IW'(NUM_STAGES - 1)) ? S_OUT0 : S_ST0;
      S_OUT0: begin
        ma = MA_W'(y_r);
        mb = signed'(MB_W'(out_gain_r));
        st_nxt = S_OUT1;
      end
      S_OUT1: st_nxt = S_DONE;
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // product register
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  // filter state: cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STAGES; i++) s_r[i] <= '0;
      fs_r   <= '0;
      prev_r <= '0;
      idx_r  <= '0;
      ret_r  <= S_IDLE;
    end else begin
      case (st_r)
        S_FBT: ret_r <= S_FB1;
        // integrate the feedback smoother
        S_FB4: fs_r <= fs_r + p16[26:0];
        S_FB6: idx_r <= '0;
        S_ST1: ret_r <= S_ST2;
        S_ST4: ret_r <= S_ST5;
        S_ST8: begin
          // new stage state is taken before the clip
          s_r[idx_r] <= SAMPLE_BITS'(kill(32'(nv)));
          if (idx_r != IW'(NUM_STAGES - 1)) idx_r <= idx_r + 1'b1;
        end
        S_OUT1: begin
          prev_r <= SAMPLE_BITS'(kill(32'(sat_s(p16[31:0]))));
          fs_r   <= 27'(kill(32'(fs_r)));
        end
        default: ;
      endcase
    end
  end

  // working registers: no reset needed
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (in_valid) x_r <= in_sample_in;
      S_K04:  att_r <= p16[24:0];
      S_COMP: comp_r <= 19'd65536 + p16[18:0];
      S_PRV:  ac_r <= p16[27:0];
      S_FBT:  t_r <= p16[SAMPLE_BITS-1:0];
      S_TH0: begin
        neg_r <= seg.neg;
        sat_r <= seg.sat;
        lo_r  <= seg.lo;
      end
      S_TH1:  r_r <= seg_sign(neg_r, rr);
      S_FB2:  diff_r <= SAMPLE_BITS'(27'(sfb) - fs_r);
      S_FB6:  y_r <= sat_s(u32);
      S_ST1:  t_r <= p16[SAMPLE_BITS-1:0];
      S_ST3:  ca_r <= p16[17:0];
      S_ST4:  t_r <= p16[SAMPLE_BITS-1:0];
      S_ST6:  diff_r <= SAMPLE_BITS'(dd);
      S_ST8:  y_r <= ycl[SAMPLE_BITS-1:0];
      S_OUT1: res_r <= sat_s(p16[31:0]);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_sample_r <= res_r;
  end

  `OLPF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
  `OLPF_ASSERT_NEXT(a_hold_done, clk, rst_n, st_r == S_DONE && out_valid_r && !out_ready, st_r == S_DONE)
  `OLPF_ASSERT_NOW(a_idx_range, clk, rst_n, 1'b1, idx_r <= IW'(NUM_STAGES - 1))
  `OLPF_ASSERT_NOW(a_prev_bounded, clk, rst_n, 1'b1, prev_r < 24'sd6553600 && prev_r > -24'sd6553600)

endmodule
